### rtl/uqtpd_pkg.sv
// Shared types and character constants of the request-target tokenizer.
package uqtpd_pkg;

	// Most results that one input byte can cause
	localparam int MAX_RES = 5;

	// Delimiters and special bytes
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Offset added to a hex letter's position after 'a' or 'A'
	localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

	typedef enum logic [2:0] {
		SEC_PATH  = 3'd0,
		SEC_KEY   = 3'd1,
		SEC_VALUE = 3'd2,
		SEC_DONE  = 3'd3,
		SEC_ERROR = 3'd4
	} sec_t;

	typedef enum logic [2:0] {
		K_PATH_BYTE  = 3'd0,
		K_KEY_BYTE   = 3'd1,
		K_VALUE_BYTE = 3'd2,
		K_PATH_END   = 3'd3,
		K_KEY_END    = 3'd4,
		K_VALUE_END  = 3'd5,
		K_NO_EQUALS  = 3'd6,
		K_TARGET_END = 3'd7
	} kind_t;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} res_t;

	// All results of one input byte, entry 0 first
	typedef struct packed {
		logic [2:0]              cnt;
		res_t [MAX_RES-1:0]      res;
	} cmd_t;

endpackage

### rtl/url_query_tokenizer_percent_decode_core.sv
// Top level of the request-target tokenizer with percent decoding.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_stall   | char_in, final_char
//  out     | output    | out_valid / out_stall | kind, char_out, run_last
//
// One byte is accepted per cycle while the result queue has room; a byte that
// causes no result is consumed in that cycle. The back end drives the results of
// a list one at a time; one byte causes up to 5 results.
// The queue holds QUEUE_DEPTH result lists; the front stalls only when it is full.
// Reset clears the section and escape state, the queue and the output valid.
// A stalled output holds its result; the front keeps taking bytes until the queue fills.
module url_query_tokenizer_percent_decode_core import uqtpd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       final_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] char_out,
	output logic       run_last
);

	logic q_full, q_push, q_pop, q_empty;
	cmd_t q_data, q_head;

	uqtpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.final_char(final_char),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	uqtpd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	uqtpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.char_out (char_out),
		.run_last (run_last)
	);

endmodule

### rtl/uqtpd_front.sv
// Front end: accepts request bytes, tracks section and escape state, builds result lists.
module uqtpd_front import uqtpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       final_char,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_data
);

	// Hex digit value; bit 4 marks a valid digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h61 + HEX_LETTER_BASE;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h41 + HEX_LETTER_BASE;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	// Append one result if there is room
	function automatic cmd_t add_res(input cmd_t c, input kind_t k, input logic [7:0] ch);
		cmd_t r;
		r = c;
		if (r.cnt < 3'(MAX_RES)) begin
			r.res[r.cnt] = '{kind: k, ch: ch};
			r.cnt = r.cnt + 3'd1;
		end
		return r;
	endfunction

	// Emit a pending escape literally
	function automatic cmd_t flush_esc(input cmd_t c, input kind_t k, input logic [1:0] esc,
			input logic [7:0] fh);
		cmd_t r;
		r = c;
		if (esc != 2'd0) begin
			r = add_res(r, k, CH_PCT);
		end
		if (esc == 2'd2) begin
			r = add_res(r, k, fh);
		end
		return r;
	endfunction

	sec_t       sec_q, sec_mid;
	logic [1:0] esc_q, esc_mid;
	logic [7:0] fh_q, fh_mid;

	logic       accept;
	logic       is_hash, is_quest, is_amp, is_eq, is_pct, is_plus;
	logic [4:0] c_hex, fh_hex;
	logic       data_en, esc_take, esc_done, fresh;
	kind_t      dk;
	cmd_t       cmd;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign q_push   = accept && (cmd.cnt != 3'd0);
	assign q_data   = cmd;

	// Classify the byte
	always_comb begin
		is_hash  = (char_in == CH_HASH);
		is_quest = (char_in == CH_QUEST);
		is_amp   = (char_in == CH_AMP);
		is_eq    = (char_in == CH_EQ);
		is_pct   = (char_in == CH_PCT);
		is_plus  = (char_in == CH_PLUS);
		c_hex    = hex_val(char_in);
		fh_hex   = hex_val(fh_q);
		dk       = (sec_q == SEC_KEY) ? K_KEY_BYTE : K_VALUE_BYTE;
		data_en  = ((sec_q == SEC_KEY) && !is_eq && !is_amp && !is_hash) ||
			((sec_q == SEC_VALUE) && !is_amp && !is_hash);
		esc_take = data_en && (esc_q == 2'd1) && c_hex[4];
		esc_done = data_en && (esc_q == 2'd2) && c_hex[4];
		fresh    = data_en && !esc_take && !esc_done;
	end

	// Next state after the byte, before the end-of-target return
	always_comb begin
		sec_mid = sec_q;
		esc_mid = esc_q;
		fh_mid  = fh_q;
		case (sec_q)
			SEC_PATH: begin
				if (is_quest) begin
					sec_mid = SEC_KEY;
				end else if (is_hash) begin
					sec_mid = SEC_DONE;
				end
			end
			SEC_KEY: begin
				if (is_eq) begin
					sec_mid = SEC_VALUE;
					esc_mid = 2'd0;
				end else if (is_amp || is_hash) begin
					sec_mid = SEC_ERROR;
					esc_mid = 2'd0;
				end
			end
			SEC_VALUE: begin
				if (is_amp) begin
					sec_mid = SEC_KEY;
					esc_mid = 2'd0;
				end else if (is_hash) begin
					sec_mid = SEC_DONE;
					esc_mid = 2'd0;
				end
			end
			default: begin
			end
		endcase
		if (data_en) begin
			if (esc_take) begin
				esc_mid = 2'd2;
				fh_mid  = char_in;
			end else if (fresh && is_pct) begin
				esc_mid = 2'd1;
			end else begin
				esc_mid = 2'd0;
			end
		end
	end

	// Build the result list of the byte
	always_comb begin
		cmd = '0;
		case (sec_q)
			SEC_PATH: begin
				if (is_quest || is_hash) begin
					cmd = add_res(cmd, K_PATH_END, 8'h00);
				end else begin
					cmd = add_res(cmd, K_PATH_BYTE, char_in);
				end
			end
			SEC_KEY: begin
				if (is_eq) begin
					cmd = flush_esc(cmd, K_KEY_BYTE, esc_q, fh_q);
					cmd = add_res(cmd, K_KEY_END, 8'h00);
				end else if (is_amp || is_hash) begin
					cmd = add_res(cmd, K_NO_EQUALS, 8'h00);
				end
			end
			SEC_VALUE: begin
				if (is_amp || is_hash) begin
					cmd = flush_esc(cmd, K_VALUE_BYTE, esc_q, fh_q);
					cmd = add_res(cmd, K_VALUE_END, 8'h00);
				end
			end
			default: begin
			end
		endcase
		if (data_en) begin
			if (esc_done) begin
				cmd = add_res(cmd, dk, {fh_hex[3:0], c_hex[3:0]});
			end else if (esc_q == 2'd1 && !esc_take) begin
				cmd = add_res(cmd, dk, CH_PCT);
			end else if (esc_q == 2'd2) begin
				cmd = add_res(cmd, dk, CH_PCT);
				cmd = add_res(cmd, dk, fh_q);
			end
			if (fresh && !is_pct) begin
				cmd = add_res(cmd, dk, is_plus ? CH_SPACE : char_in);
			end
		end
		if (final_char) begin
			case (sec_mid)
				SEC_PATH: begin
					cmd = add_res(cmd, K_PATH_END, 8'h00);
				end
				SEC_KEY: begin
					cmd = add_res(cmd, K_NO_EQUALS, 8'h00);
				end
				SEC_VALUE: begin
					cmd = flush_esc(cmd, K_VALUE_BYTE, esc_mid, fh_mid);
					cmd = add_res(cmd, K_VALUE_END, 8'h00);
				end
				default: begin
				end
			endcase
			cmd = add_res(cmd, K_TARGET_END, 8'h00);
		end
	end

	// Advance state on each accepted byte; return to start after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= SEC_PATH;
			esc_q <= 2'd0;
			fh_q  <= 8'h00;
		end else if (accept) begin
			if (final_char) begin
				sec_q <= SEC_PATH;
				esc_q <= 2'd0;
				fh_q  <= 8'h00;
			end else begin
				sec_q <= sec_mid;
				esc_q <= esc_mid;
				fh_q  <= fh_mid;
			end
		end
	end

	// A held second escape byte is always a hex digit
	a_fh_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(esc_q == 2'd2) |-> fh_hex[4])
		else $error("pending escape digit is not hex");

	// A pushed list holds between one and the maximum of results
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_data.cnt >= 3'd1 && q_data.cnt <= 3'(MAX_RES)))
		else $error("bad result count pushed");

endmodule

### rtl/uqtpd_queue.sv
// Short queue of result lists between the front and back ends.
module uqtpd_queue import uqtpd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// Store a pushed list
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

### rtl/uqtpd_back.sv
// Back end: walks each queued result list and drives results through an output register.
module uqtpd_back import uqtpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] char_out,
	output logic       run_last
);

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] char_q;
	logic       last_q;
	logic [2:0] idx_q;

	logic       load;
	logic       sel_last;
	res_t       sel;

	assign load     = !empty && (!out_valid_q || !out_stall);
	assign sel      = head.res[idx_q];
	assign sel_last = (idx_q == head.cnt - 3'd1);
	assign pop      = load && sel_last;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign char_out  = char_q;
	assign run_last  = last_q;

	// Load the next result when the output register is free
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= sel.kind;
			char_q <= sel.ch;
			last_q <= sel_last;
		end
	end

	// Advance within the list; hold valid while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= sel_last ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The walk index starts fresh whenever no list waits
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (idx_q == 3'd0))
		else $error("list index left mid-way with empty queue");

endmodule

### tb/url_query_tokenizer_percent_decode_core_tb.sv
// Testbench of the request-target tokenizer: directed table, random targets, token predictor.
module url_query_tokenizer_percent_decode_core_tb import uqtpd_pkg::*;;

	localparam int RANDOM_ITEMS = 132;
	localparam int DRAIN_CYCLES = 60;
	localparam int IDLE_LIMIT   = 5000;

	typedef struct {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
	} token_t;

	typedef struct {
		logic [7:0] ch;
		bit         fin;
		bit         typed;
		kind_t      kind;
		logic [7:0] res_ch;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_in = 8'h00;
	logic       final_char = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] char_out;
	logic       run_last;

	// Tokenizer state as the predictor sees it
	sec_t       cur_sec = SEC_PATH;
	logic [1:0] esc_len = 2'd0;
	logic [7:0] esc_hi = 8'h00;
	logic       pair_seen = 1'b0;

	token_t step_tokens[$];
	token_t pending_tokens[$];
	row_t   directed_rows[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int sent_count = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	url_query_tokenizer_percent_decode_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.final_char(final_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.char_out  (char_out),
		.run_last  (run_last)
	);

	always #5 clk = ~clk;

	// Hex digit value, -1 for any other byte
	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a" + HEX_LETTER_BASE);
		if (c >= "A" && c <= "F") return int'(c - "A" + HEX_LETTER_BASE);
		return -1;
	endfunction

	function automatic void put_token(input kind_t k, input logic [7:0] c);
		if (step_tokens.size() < MAX_RES) step_tokens.push_back('{k, c, 1'b0});
	endfunction

	// Decode one key or value byte, advancing any pending escape
	function automatic void take_text_byte(input kind_t k, input logic [7:0] c);
		int lo;
		pair_seen = 1'b1;
		if (esc_len == 2'd1) begin
			if (hex_nibble(c) >= 0) begin
				esc_hi = c;
				esc_len = 2'd2;
				return;
			end
			put_token(k, CH_PCT);
			esc_len = 2'd0;
		end else if (esc_len == 2'd2) begin
			lo = hex_nibble(c);
			if (lo >= 0) begin
				put_token(k, 8'(hex_nibble(esc_hi) * 16 + lo));
				esc_len = 2'd0;
				return;
			end
			put_token(k, CH_PCT);
			put_token(k, esc_hi);
			esc_len = 2'd0;
		end
		if (c == CH_PCT) esc_len = 2'd1;
		else if (c == CH_PLUS) put_token(k, CH_SPACE);
		else put_token(k, c);
	endfunction

	// Emit a pending escape literally
	function automatic void flush_pending_escape(input kind_t k);
		if (esc_len >= 2'd1) put_token(k, CH_PCT);
		if (esc_len == 2'd2) put_token(k, esc_hi);
		esc_len = 2'd0;
	endfunction

	function automatic void mark_no_equals();
		esc_len = 2'd0;
		put_token(K_NO_EQUALS, 8'h00);
		cur_sec = SEC_ERROR;
	endfunction

	// Work out the tokens that one request causes into step_tokens
	function automatic void predict_tokens(input logic [7:0] c, input bit f);
		step_tokens.delete();
		case (cur_sec)
			SEC_PATH: begin
				if (c == CH_QUEST) begin
					put_token(K_PATH_END, 8'h00);
					cur_sec = SEC_KEY;
					pair_seen = 1'b0;
				end else if (c == CH_HASH) begin
					put_token(K_PATH_END, 8'h00);
					cur_sec = SEC_DONE;
				end else begin
					put_token(K_PATH_BYTE, c);
				end
			end
			SEC_KEY: begin
				if (c == CH_EQ) begin
					flush_pending_escape(K_KEY_BYTE);
					put_token(K_KEY_END, 8'h00);
					cur_sec = SEC_VALUE;
				end else if (c == CH_AMP || c == CH_HASH) begin
					mark_no_equals();
				end else begin
					take_text_byte(K_KEY_BYTE, c);
				end
			end
			SEC_VALUE: begin
				if (c == CH_AMP || c == CH_HASH) begin
					flush_pending_escape(K_VALUE_BYTE);
					put_token(K_VALUE_END, 8'h00);
					cur_sec = (c == CH_AMP) ? SEC_KEY : SEC_DONE;
					pair_seen = 1'b0;
				end else begin
					take_text_byte(K_VALUE_BYTE, c);
				end
			end
			default: ;
		endcase
		// Close the open segment at the end of the target
		if (f) begin
			if (cur_sec == SEC_PATH) begin
				put_token(K_PATH_END, 8'h00);
			end else if (cur_sec == SEC_KEY) begin
				mark_no_equals();
			end else if (cur_sec == SEC_VALUE) begin
				flush_pending_escape(K_VALUE_BYTE);
				put_token(K_VALUE_END, 8'h00);
			end
			put_token(K_TARGET_END, 8'h00);
			cur_sec = SEC_PATH;
			esc_len = 2'd0;
			esc_hi = 8'h00;
			pair_seen = 1'b0;
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
	endfunction

	// Offer one request, wait for it to be taken, then queue its tokens
	task automatic send_byte(input logic [7:0] c, input bit f, input bit typed,
			input kind_t tk, input logic [7:0] tc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		final_char <= f;
		do @(posedge clk); while (in_stall);
		sent_count++;
		predict_tokens(c, f);
		if (typed) begin
			pending_tokens.push_back('{tk, tc, 1'b1});
		end else begin
			foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
		end
	endtask

	task automatic add_row(input logic [7:0] c, input bit f, input bit typed,
			input kind_t k, input logic [7:0] rc);
		directed_rows.push_back('{c, f, typed, k, rc});
	endtask

	// Pick a key, value or path byte: hex digits, escapes, plus signs, letters g to z, some noise
	function automatic logic [7:0] text_byte();
		string hex_chars;
		int r;
		hex_chars = "0123456789abcdefABCDEF";
		r = $urandom_range(99);
		if (r < 28) return hex_chars[$urandom_range(21)];
		if (r < 44) return CH_PCT;
		if (r < 52) return CH_PLUS;
		if (r < 80) return 8'($urandom_range(8'h67, 8'h7a));
		return 8'($urandom_range(255));
	endfunction

	// Build one request target, mostly well formed, and send it
	task automatic send_random_target();
		logic [7:0] bytes_q[$];
		int n_pairs;
		repeat ($urandom_range(3)) bytes_q.push_back(text_byte());
		if ($urandom_range(9) > 0) begin
			bytes_q.push_back(CH_QUEST);
			n_pairs = $urandom_range(1, 3);
			for (int p = 0; p < n_pairs; p++) begin
				if (p > 0) bytes_q.push_back(CH_AMP);
				repeat ($urandom_range(3)) bytes_q.push_back(text_byte());
				if ($urandom_range(9) > 0) bytes_q.push_back(CH_EQ);
				repeat ($urandom_range(4)) bytes_q.push_back(text_byte());
			end
		end
		if ($urandom_range(9) == 0) begin
			bytes_q.push_back(CH_HASH);
			repeat ($urandom_range(2)) bytes_q.push_back(text_byte());
		end
		if (bytes_q.size() == 0) bytes_q.push_back(text_byte());
		foreach (bytes_q[i])
			send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, K_PATH_BYTE, 8'h00);
	endtask

	// Stall the result side at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check each taken token against the oldest expected one
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token: kind %0d char %h last %b", kind, char_out, run_last);
			end else if (kind != pending_tokens[0].kind || char_out != pending_tokens[0].ch ||
					run_last != pending_tokens[0].last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("token mismatch: expected kind %0d char %h last %b, got kind %0d char %h last %b",
						pending_tokens[0].kind, pending_tokens[0].ch, pending_tokens[0].last,
						kind, char_out, run_last);
				void'(pending_tokens.pop_front());
			end else begin
				void'(pending_tokens.pop_front());
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		// Directed table: reset state, byte extremes, delimiters, escapes, errors
		add_row(8'h00, 1'b0, 1'b1, K_PATH_BYTE, 8'h00);
		add_row(8'hFF, 1'b0, 1'b1, K_PATH_BYTE, 8'hFF);
		add_row(CH_QUEST, 1'b0, 1'b1, K_PATH_END, 8'h00);
		add_row(CH_AMP, 1'b0, 1'b1, K_NO_EQUALS, 8'h00);
		add_row("x", 1'b1, 1'b1, K_TARGET_END, 8'h00);
		add_row(CH_HASH, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("a", 1'b1, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_QUEST, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_PCT, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("4", 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_EQ, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_PCT, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("G", 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_PLUS, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_AMP, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("k", 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_EQ, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_PCT, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("7", 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_PCT, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("4", 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("e", 1'b1, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_QUEST, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_EQ, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_PCT, 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("B", 1'b0, 1'b0, K_PATH_BYTE, 8'h00);
		add_row(CH_PCT, 1'b1, 1'b0, K_PATH_BYTE, 8'h00);
		add_row("a", 1'b1, 1'b0, K_PATH_BYTE, 8'h00);

		// Hold reset, then release
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, then random targets over three idle profiles
		send_idle_pct = 32;
		recv_stall_pct = 76;
		foreach (directed_rows[i])
			send_byte(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].typed,
				directed_rows[i].kind, directed_rows[i].res_ch);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 76 : 0;
			recv_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 32 : 0;
			while (sent_count < directed_rows.size() + (phase + 1) * RANDOM_ITEMS / 3)
				send_random_target();
		end
		in_valid <= 1'b0;

		// Drain the remaining tokens, then watch for strays
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
